// ----- rtl/gcp_pkg.sv -----
package gcp_pkg;

    // fraction digits kept in the fixed-point result
    localparam int FRAC_DIGITS = 6;
    localparam longint SCALE = longint'(10) ** FRAC_DIGITS;

    // accumulator widths
    localparam int INT_W = 10;
    localparam int INT_ACC_W = INT_W + 4;
    localparam int FRAC_W = $clog2(SCALE);
    localparam int FRAC_ACC_W = FRAC_W + 4;
    localparam int CNT_W = $clog2(FRAC_DIGITS + 1);
    localparam int MAG_W = $clog2(longint'(1) << INT_W) + $clog2(SCALE);
    localparam int VAL_W = 30;
    localparam int WIDE_W = ((MAG_W > VAL_W) ? MAG_W : VAL_W) + 1;
    localparam int POW_W = 30;

    localparam logic [INT_W-1:0] INT_SAT = {INT_W{1'b1}};
    localparam logic [CNT_W-1:0] FRAC_DIGITS_C = CNT_W'(FRAC_DIGITS);

    // powers of ten for aligning the fraction
    localparam logic [POW_W-1:0] POW10 [0:9] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    // range limits and error value, scaled
    localparam logic [MAG_W-1:0] LAT_LIMIT = MAG_W'(90 * SCALE);
    localparam logic [MAG_W-1:0] LON_LIMIT = MAG_W'(360 * SCALE);
    localparam logic [VAL_W-1:0] ERR_VALUE = VAL_W'(-99 * SCALE);
    localparam logic signed [VAL_W-1:0] MIN_VALUE = VAL_W'(-90 * SCALE);
    localparam logic signed [VAL_W-1:0] MAX_VALUE = VAL_W'(360 * SCALE);

    // coordinate modes
    localparam logic MODE_LAT = 1'b0;
    localparam logic MODE_LON = 1'b1;

    // register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int RIDX_W = PADDR_W - 2;
    localparam logic [RIDX_W-1:0] REG_COORD_MODE = '0;

    // character codes
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_LO_W  = 8'h77;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] coord_value;
        logic                    is_error;
    } t_out_item;

    // snapshot of one finished term
    typedef struct packed {
        logic              coord_mode;
        logic [INT_W-1:0]  int_part;
        logic [FRAC_W-1:0] frac_part;
        logic [CNT_W-1:0]  frac_count;
        logic              sticky_digits;
        logic              negative_sign;
        logic              bad_char_seen;
        logic              int_overflow;
    } t_term;

    // scaled parts of a term
    typedef struct packed {
        logic              coord_mode;
        logic [MAG_W-1:0]  int_prod;
        logic [MAG_W-1:0]  frac_prod;
        logic [MAG_W-1:0]  limit;
        logic              sticky_digits;
        logic              negative_sign;
        logic              bad_char_seen;
        logic              int_overflow;
    } t_prod;

endpackage

// ----- rtl/gcp_char_acc.sv -----
module gcp_char_acc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  gcp_pkg::t_in_item i_item,
    input  logic              i_coord_mode,
    output gcp_pkg::t_term    o_term
);

    logic [gcp_pkg::INT_W-1:0]  r_int_part, n_int_part;
    logic [gcp_pkg::FRAC_W-1:0] r_frac_part, n_frac_part;
    logic [gcp_pkg::CNT_W-1:0]  r_frac_count, n_frac_count;
    logic r_seen_dot, n_seen_dot;
    logic r_number_done, n_number_done;
    logic r_sticky, n_sticky;
    logic r_negative, n_negative;
    logic r_bad_char, n_bad_char;
    logic r_int_ovf, n_int_ovf;

    logic [3:0]                     digit;
    logic [gcp_pkg::INT_ACC_W-1:0]  int_next;
    logic [gcp_pkg::FRAC_ACC_W-1:0] frac_next;

    // times ten plus digit, as shift and add
    assign digit = i_item.char_code[3:0];
    assign int_next = (gcp_pkg::INT_ACC_W'(r_int_part) << 3)
                    + (gcp_pkg::INT_ACC_W'(r_int_part) << 1)
                    + gcp_pkg::INT_ACC_W'(digit);
    assign frac_next = (gcp_pkg::FRAC_ACC_W'(r_frac_part) << 3)
                     + (gcp_pkg::FRAC_ACC_W'(r_frac_part) << 1)
                     + gcp_pkg::FRAC_ACC_W'(digit);

    // character decode
    always_comb begin
        n_int_part    = r_int_part;
        n_frac_part   = r_frac_part;
        n_frac_count  = r_frac_count;
        n_seen_dot    = r_seen_dot;
        n_number_done = r_number_done;
        n_sticky      = r_sticky;
        n_negative    = r_negative;
        n_bad_char    = r_bad_char;
        n_int_ovf     = r_int_ovf;
        case (i_item.char_code) inside
            gcp_pkg::CH_MINUS: begin
                n_negative = 1'b1;
            end
            [gcp_pkg::CH_ZERO:gcp_pkg::CH_NINE]: begin
                if (!r_number_done) begin
                    if (!r_seen_dot) begin
                        if (int_next > gcp_pkg::INT_ACC_W'(gcp_pkg::INT_SAT)) begin
                            n_int_part = gcp_pkg::INT_SAT;
                            n_int_ovf  = 1'b1;
                        end else begin
                            n_int_part = int_next[gcp_pkg::INT_W-1:0];
                        end
                    end else if (r_frac_count < gcp_pkg::FRAC_DIGITS_C) begin
                        n_frac_part  = frac_next[gcp_pkg::FRAC_W-1:0];
                        n_frac_count = r_frac_count + 1'b1;
                    end else if (digit != 4'd0) begin
                        n_sticky = 1'b1;
                    end
                end
            end
            gcp_pkg::CH_DOT: begin
                if (r_seen_dot) begin
                    n_number_done = 1'b1;
                end else begin
                    n_seen_dot = 1'b1;
                end
            end
            gcp_pkg::CH_UP_N, gcp_pkg::CH_LO_N, gcp_pkg::CH_UP_E, gcp_pkg::CH_LO_E: begin
                // positive hemisphere letter, valid only in its own mode
                if ((i_coord_mode == gcp_pkg::MODE_LAT) ==
                    (i_item.char_code == gcp_pkg::CH_UP_N ||
                     i_item.char_code == gcp_pkg::CH_LO_N)) begin
                    n_negative = 1'b0;
                end else begin
                    n_bad_char = 1'b1;
                end
            end
            gcp_pkg::CH_UP_S, gcp_pkg::CH_LO_S, gcp_pkg::CH_UP_W, gcp_pkg::CH_LO_W: begin
                // negative hemisphere letter, valid only in its own mode
                if ((i_coord_mode == gcp_pkg::MODE_LAT) ==
                    (i_item.char_code == gcp_pkg::CH_UP_S ||
                     i_item.char_code == gcp_pkg::CH_LO_S)) begin
                    n_negative = 1'b1;
                end else begin
                    n_bad_char = 1'b1;
                end
            end
            default: begin
                n_bad_char = 1'b1;
            end
        endcase
    end

    // term state, cleared by reset and after every terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_part    <= '0;
            r_frac_part   <= '0;
            r_frac_count  <= '0;
            r_seen_dot    <= 1'b0;
            r_number_done <= 1'b0;
            r_sticky      <= 1'b0;
            r_negative    <= 1'b0;
            r_bad_char    <= 1'b0;
            r_int_ovf     <= 1'b0;
        end else if (i_take) begin
            if (i_item.is_end) begin
                r_int_part    <= '0;
                r_frac_part   <= '0;
                r_frac_count  <= '0;
                r_seen_dot    <= 1'b0;
                r_number_done <= 1'b0;
                r_sticky      <= 1'b0;
                r_negative    <= 1'b0;
                r_bad_char    <= 1'b0;
                r_int_ovf     <= 1'b0;
            end else begin
                r_int_part    <= n_int_part;
                r_frac_part   <= n_frac_part;
                r_frac_count  <= n_frac_count;
                r_seen_dot    <= n_seen_dot;
                r_number_done <= n_number_done;
                r_sticky      <= n_sticky;
                r_negative    <= n_negative;
                r_bad_char    <= n_bad_char;
                r_int_ovf     <= n_int_ovf;
            end
        end
    end

    // snapshot for the result pipeline
    always_comb begin
        o_term.coord_mode    = i_coord_mode;
        o_term.int_part      = r_int_part;
        o_term.frac_part     = r_frac_part;
        o_term.frac_count    = r_frac_count;
        o_term.sticky_digits = r_sticky;
        o_term.negative_sign = r_negative;
        o_term.bad_char_seen = r_bad_char;
        o_term.int_overflow  = r_int_ovf;
    end

endmodule

// ----- rtl/gcp_result_pipe.sv -----
module gcp_result_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gcp_pkg::t_term     i_term,
    output logic               o_valid,
    input  logic               i_ready,
    output gcp_pkg::t_out_item o_item
);

    logic r_a_valid, r_b_valid, r_c_valid;
    logic a_ready, b_ready, c_ready;
    gcp_pkg::t_term     r_a;
    gcp_pkg::t_prod     r_b, n_b;
    gcp_pkg::t_out_item r_c, n_c;

    logic [gcp_pkg::MAG_W-1:0]  mag;
    logic [gcp_pkg::WIDE_W-1:0] wide_val;
    logic                       err;

    // stage flow control
    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // scale integer and fraction parts
    always_comb begin
        n_b.coord_mode    = r_a.coord_mode;
        n_b.int_prod      = gcp_pkg::MAG_W'(r_a.int_part)
                          * gcp_pkg::MAG_W'(gcp_pkg::SCALE);
        n_b.frac_prod     = gcp_pkg::MAG_W'(r_a.frac_part)
                          * gcp_pkg::MAG_W'(gcp_pkg::POW10[4'(gcp_pkg::FRAC_DIGITS_C
                                                               - r_a.frac_count)]);
        n_b.limit         = (r_a.coord_mode == gcp_pkg::MODE_LON) ?
                            gcp_pkg::LON_LIMIT : gcp_pkg::LAT_LIMIT;
        n_b.sticky_digits = r_a.sticky_digits;
        n_b.negative_sign = r_a.negative_sign;
        n_b.bad_char_seen = r_a.bad_char_seen;
        n_b.int_overflow  = r_a.int_overflow;
    end

    // sum, limit check and sign handling
    always_comb begin
        mag = r_b.int_prod + r_b.frac_prod;
        err = r_b.bad_char_seen || r_b.int_overflow || (mag > r_b.limit)
           || ((mag == r_b.limit) && r_b.sticky_digits);
        if (!r_b.negative_sign) begin
            wide_val = gcp_pkg::WIDE_W'(mag);
        end else if (r_b.coord_mode == gcp_pkg::MODE_LAT) begin
            wide_val = gcp_pkg::WIDE_W'(0) - gcp_pkg::WIDE_W'(mag);
        end else begin
            wide_val = gcp_pkg::WIDE_W'(r_b.limit) - gcp_pkg::WIDE_W'(mag);
        end
        n_c.is_error    = err;
        n_c.coord_value = err ? gcp_pkg::ERR_VALUE : wide_val[gcp_pkg::VAL_W-1:0];
    end

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= i_term;
        end
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
        if (c_ready && r_b_valid) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c;

endmodule

// ----- rtl/geo_coordinate_text_parser.sv -----
// Coordinate text parser: turns an ASCII coordinate term into micro-degrees.
// Input channel (i_in_valid / o_in_ready / i_in_item): one character per item;
// an item with is_end set closes the term and its character is ignored.
// Digits and dots build the magnitude, '-' or a hemisphere letter sets the
// sign, and any other byte flags an error that shows up with the result.
// Output channel (o_out_valid / i_out_ready / o_out_item): one result per
// terminator, the signed value or the error value with is_error set.
// Throughput is one item per cycle while o_in_ready is high, characters and
// terminators alike; the per-character update is a registered times-ten accumulate.
// A result passes the snapshot register, the scaling multiply register, then
// sum and limit compare into the result register.
// When the receiver stalls, the three result stages fill up; characters are
// still taken while the first stage has room, then o_in_ready drops.
// coord_mode is written over the APB port (address 0); the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the term state, the result stages and coord_mode (latitude).
module geo_coordinate_text_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  gcp_pkg::t_in_item            i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output gcp_pkg::t_out_item           o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gcp_pkg::PADDR_W-1:0]  paddr,
    input  logic [gcp_pkg::PDATA_W-1:0]  pwdata,
    output logic [gcp_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    logic r_coord_mode;
    logic reg_hit;
    logic take;
    logic pipe_ready;
    gcp_pkg::t_term term;

    // configuration register
    assign reg_hit = (paddr[gcp_pkg::PADDR_W-1:2] == gcp_pkg::REG_COORD_MODE);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_mode <= gcp_pkg::MODE_LAT;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_coord_mode <= pwdata[0];
        end
    end

    assign prdata = reg_hit ? gcp_pkg::PDATA_W'(r_coord_mode) : '0;

    // input handshake
    assign o_in_ready = pipe_ready;
    assign take       = i_in_valid && pipe_ready;

    gcp_char_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_item       (i_in_item),
        .i_coord_mode (r_coord_mode),
        .o_term       (term)
    );

    gcp_result_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid && i_in_item.is_end),
        .o_ready (pipe_ready),
        .i_term  (term),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ----- rtl/gcp_checker.sv -----
module gcp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input gcp_pkg::t_out_item o_out_item,
    input logic               pready
);

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // errors always carry the error value
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_error |->
            o_out_item.coord_value == gcp_pkg::ERR_VALUE)
        else $error("error item with wrong value");

    // good results stay inside the coordinate range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_error |->
            o_out_item.coord_value >= gcp_pkg::MIN_VALUE &&
            o_out_item.coord_value <= gcp_pkg::MAX_VALUE)
        else $error("result out of range");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind geo_coordinate_text_parser gcp_checker u_gcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item),
    .pready      (pready)
);
